### rtl/mwh_pkg.sv
// Constants, select codes and control struct shared by the word hash core.
package mwh_pkg;

	localparam logic [63:0] SEED_VALUE = 64'hBAADF00DDEADBEEF;
	localparam logic [31:0] MUL_A      = 32'hDED15DED;
	localparam logic [31:0] MUL_B      = 32'hCADAB8A9;
	localparam logic [31:0] MUL_C      = 32'h112C13AB;
	localparam logic [63:0] ADD_D      = 64'h0314159265358979;
	localparam int          ROT_FIRST  = 31;
	localparam int          ROT_SECOND = 15;

	localparam logic [1:0] OPS_HOLD = 2'd0;
	localparam logic [1:0] OPS_ROT1 = 2'd1;
	localparam logic [1:0] OPS_ROT2 = 2'd2;

	localparam logic [1:0] CS_A = 2'd0;
	localparam logic [1:0] CS_B = 2'd1;
	localparam logic [1:0] CS_C = 2'd2;

	typedef struct packed {
		logic       load_in;
		logic       mul_lo;
		logic       mul_hi;
		logic       finish;
		logic       reseed;
		logic [1:0] opsel;
		logic [1:0] csel;
	} ctrl_t;

endpackage

### rtl/mwh_mac.sv
// Shared 32x32 multiply-accumulate datapath with operand, accumulator and running value.
module mwh_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  mwh_pkg::ctrl_t     ctrl,
	input  logic [63:0]        data_word,
	output logic [63:0]        fin_sum
);
	import mwh_pkg::*;

	logic [63:0] op_q;
	logic [63:0] acc_q;
	logic [63:0] run_q;
	logic [63:0] opnd;
	logic [63:0] mixed;
	logic [31:0] mop;
	logic [31:0] cval;
	logic [63:0] prod;

	assign mixed = acc_q ^ run_q;

	always_comb begin
		unique case (ctrl.opsel)
			OPS_HOLD: opnd = op_q;
			OPS_ROT1: opnd = {acc_q[63-ROT_FIRST:0], acc_q[63:64-ROT_FIRST]};
			OPS_ROT2: opnd = {mixed[63-ROT_SECOND:0], mixed[63:64-ROT_SECOND]};
			default:  opnd = op_q;
		endcase
	end

	always_comb begin
		unique case (ctrl.csel)
			CS_A:    cval = MUL_A;
			CS_B:    cval = MUL_B;
			CS_C:    cval = MUL_C;
			default: cval = MUL_A;
		endcase
	end

	assign mop     = ctrl.mul_lo ? opnd[31:0] : op_q[63:32];
	assign prod    = {32'd0, mop} * {32'd0, cval};
	assign fin_sum = acc_q + ADD_D;

	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			op_q <= data_word;
		end else if (ctrl.mul_lo) begin
			op_q <= opnd;
		end
		if (ctrl.mul_lo) begin
			acc_q <= prod;
		end else if (ctrl.mul_hi) begin
			acc_q[63:32] <= acc_q[63:32] + prod[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= SEED_VALUE;
		end else if (ctrl.finish) begin
			run_q <= ctrl.reseed ? SEED_VALUE : fin_sum;
		end
	end

endmodule

### rtl/mwh_seq.sv
// Sequencer that steps the shared multiplier through the three mixing multiplies of a word.
module mwh_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_word,
	input  logic           out_busy,
	output logic           in_stall,
	output logic           out_load,
	output mwh_pkg::ctrl_t ctrl
);
	import mwh_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_A_LO = 3'd1;
	localparam logic [2:0] ST_A_HI = 3'd2;
	localparam logic [2:0] ST_B_LO = 3'd3;
	localparam logic [2:0] ST_B_HI = 3'd4;
	localparam logic [2:0] ST_C_LO = 3'd5;
	localparam logic [2:0] ST_C_HI = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       last_q;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		ctrl     = '0;
		out_load = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.load_in = accept;
				if (accept) state_d = ST_A_LO;
			end
			ST_A_LO: begin
				ctrl.mul_lo = 1'b1;
				ctrl.opsel  = OPS_HOLD;
				ctrl.csel   = CS_A;
				state_d     = ST_A_HI;
			end
			ST_A_HI: begin
				ctrl.mul_hi = 1'b1;
				ctrl.csel   = CS_A;
				state_d     = ST_B_LO;
			end
			ST_B_LO: begin
				ctrl.mul_lo = 1'b1;
				ctrl.opsel  = OPS_ROT1;
				ctrl.csel   = CS_B;
				state_d     = ST_B_HI;
			end
			ST_B_HI: begin
				ctrl.mul_hi = 1'b1;
				ctrl.csel   = CS_B;
				state_d     = ST_C_LO;
			end
			ST_C_LO: begin
				ctrl.mul_lo = 1'b1;
				ctrl.opsel  = OPS_ROT2;
				ctrl.csel   = CS_C;
				state_d     = ST_C_HI;
			end
			ST_C_HI: begin
				ctrl.mul_hi = 1'b1;
				ctrl.csel   = CS_C;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (!last_q || !out_busy) begin
					ctrl.finish = 1'b1;
					ctrl.reseed = last_q;
					out_load    = last_q;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) last_q <= last_word;
		end
	end

endmodule

### rtl/murmur_style_word_hash_core.sv
// Top level of the streaming 64-bit word hash core.
// Each 64-bit word is folded into a running value that starts at the seed
// 0xBAADF00DDEADBEEF; on a word marked last the finished hash is sent as one
// transaction on the output channel and the seed is reloaded. A word is
// accepted, then makes six passes through a single shared 32x32
// multiplier (each of the three 64-bit by 32-bit multiplies takes a low
// and a high pass) and gets one final add before the core takes the next
// word. A finished hash waits in an output register; the last word of
// the next message holds in its final cycle while that register is still
// stalled.
module murmur_style_word_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);
	import mwh_pkg::*;

	ctrl_t       ctrl;
	logic [63:0] fin_sum;
	logic        out_load;
	logic        out_busy;
	logic        out_valid_q;
	logic [63:0] hash_q;

	assign out_busy   = out_valid_q && out_stall;
	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	mwh_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_word (last_word),
		.out_busy  (out_busy),
		.in_stall  (in_stall),
		.out_load  (out_load),
		.ctrl      (ctrl)
	);

	mwh_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.data_word (data_word),
		.fin_sum   (fin_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) hash_q <= fin_sum;
	end

endmodule

### dv/murmur_style_word_hash_checker.sv
// Channel monitor for the word hash core: predicts each finished hash and compares it.
`timescale 1ns / 100ps
module murmur_style_word_hash_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] data_word,
	input  logic        last_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] hash_value,
	output int          fail_count,
	output int          pending_hashes
);
	import mwh_pkg::*;

	logic [63:0] running_hash;
	logic [63:0] expected_hashes[$];

	function automatic logic [63:0] fold_in_word(input logic [63:0] acc, input logic [63:0] w);
		logic [63:0] k;
		logic [63:0] x;
		k = w * {32'd0, MUL_A};
		k = (k << ROT_FIRST) | (k >> (64 - ROT_FIRST));
		k = k * {32'd0, MUL_B};
		x = k ^ acc;
		x = (x << ROT_SECOND) | (x >> (64 - ROT_SECOND));
		return x * {32'd0, MUL_C} + ADD_D;
	endfunction

	initial begin
		fail_count = 0;
		pending_hashes = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] next_hash;
		logic [63:0] want;
		if (!arst_n) begin
			running_hash = SEED_VALUE;
			expected_hashes.delete();
		end else begin
			if (in_valid && !in_stall) begin
				next_hash = fold_in_word(running_hash, data_word);
				if (last_word) begin
					expected_hashes.push_back(next_hash);
					running_hash = SEED_VALUE;
				end else begin
					running_hash = next_hash;
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_hashes.size() == 0) begin
					fail_count = fail_count + 1;
					$display("%0t: unexpected hash transaction, expected none, actual %h",
						$time, hash_value);
				end else begin
					want = expected_hashes.pop_front();
					if (hash_value !== want) begin
						fail_count = fail_count + 1;
						$display("%0t: hash_value mismatch, expected %h, actual %h",
							$time, want, hash_value);
					end
				end
			end
		end
		pending_hashes = expected_hashes.size();
	end

endmodule

### dv/tb_murmur_style_word_hash_core.sv
// Testbench top for the word hash core: clock, reset, word stream, output stalls and verdict.
`timescale 1ns / 100ps
module tb_murmur_style_word_hash_core;
	import mwh_pkg::*;

	localparam int RANDOM_WORDS = 1900;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 24;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] data_word;
	logic        last_word;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] hash_value;
	int          fail_count;
	int          pending_hashes;
	int          cycle_count;

	murmur_style_word_hash_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_word  (data_word),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

	murmur_style_word_hash_checker hash_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_word      (data_word),
		.last_word      (last_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hash_value     (hash_value),
		.fail_count     (fail_count),
		.pending_hashes (pending_hashes)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("FAIL murmur_style_word_hash_core");
		$finish;
	end

	task automatic send_word(input logic [63:0] w, input logic is_last);
		@(negedge clk);
		in_valid  <= 1'b1;
		data_word <= w;
		last_word <= is_last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic sender_gap();
		int r;
		int n;
		r = $urandom_range(0, 9);
		if (r < 6)
			n = 0;
		else if (r < 9)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(5, 30);
		if (n > 0) begin
			@(negedge clk);
			in_valid  <= 1'b0;
			data_word <= {$urandom, $urandom};
			last_word <= 1'($urandom_range(0, 1));
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic logic [63:0] pick_word();
		int bit_pos;
		bit_pos = $urandom_range(0, 63);
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return '1;
			2: return 64'd1 << bit_pos;
			3: return ~(64'd1 << bit_pos);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		int r;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				repeat ($urandom_range(1, 20)) begin
					@(negedge clk);
					out_stall <= ($urandom_range(0, 3) == 0);
				end
			end else if (r < 8) begin
				@(negedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(5, 60)) @(negedge clk);
			end else begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat ($urandom_range(10, 60)) @(negedge clk);
			end
		end
	end

	initial begin
		int words_sent;
		int msg_len;
		int r;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_word = 64'd0;
		last_word = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word(64'd0, 1'b1);
		send_word('1, 1'b1);
		send_word(64'd1, 1'b1);
		sender_gap();
		send_word(64'h8000_0000_0000_0000, 1'b1);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		send_word(64'h5555_5555_5555_5555, 1'b1);
		send_word(SEED_VALUE, 1'b1);
		send_word(64'd0, 1'b0);
		send_word(64'd0, 1'b0);
		send_word(64'd0, 1'b1);
		send_word('1, 1'b0);
		send_word('1, 1'b1);
		sender_gap();
		send_word(64'h0123_4567_89AB_CDEF, 1'b0);
		send_word(64'h8000_0000_0000_0001, 1'b0);
		send_word(64'hFEDC_BA98_7654_3210, 1'b0);
		send_word(64'h7FFF_FFFF_FFFF_FFFE, 1'b1);

		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			r = $urandom_range(0, 19);
			if (r < 10)
				msg_len = $urandom_range(1, 3);
			else if (r < 17)
				msg_len = $urandom_range(4, 10);
			else
				msg_len = $urandom_range(11, 40);
			for (int i = 0; i < msg_len; i++) begin
				sender_gap();
				send_word(pick_word(), i == msg_len - 1);
				words_sent = words_sent + 1;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_hashes != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_hashes == 0)
			$display("PASS murmur_style_word_hash_core");
		else
			$display("FAIL murmur_style_word_hash_core");
		$finish;
	end

endmodule
